// File: src/sacl_pkg.sv
// shared constants and types for the set-associative cache lookup
// no dependencies; used by the interfaces, the way logic and the top level
package sacl_pkg;

  // default geometry
  localparam int unsigned DEF_WAYS        = 4;
  localparam int unsigned DEF_SET_BITS    = 6;
  localparam int unsigned DEF_OFFSET_BITS = 6;
  localparam int unsigned DEF_ADDR_BITS   = 32;

  // fixed widths of the result fields
  localparam int unsigned WAY_OUT_W  = 2;
  localparam int unsigned VTAG_OUT_W = 20;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                  hit;
    logic [WAY_OUT_W-1:0]  way;
    logic                  writeback;
    logic [VTAG_OUT_W-1:0] victim_tag;
  } res_t;

endpackage

// File: src/sacl_if.sv
// request and response channel interfaces of the cache lookup
// depends on sacl_pkg for default and result field widths
interface sacl_req_if #(
  parameter int unsigned ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface sacl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [sacl_pkg::WAY_OUT_W-1:0]  way;
  logic                            writeback;
  logic [sacl_pkg::VTAG_OUT_W-1:0] victim_tag;

  modport source (output valid, output hit, output way, output writeback,
                  output victim_tag, input ready);
  modport sink   (input valid, input hit, input way, input writeback,
                  input victim_tag, output ready);
endinterface

// File: src/sacl_row_ram.sv
// one-write one-read memory holding a full set row per entry
// registered read data; no dependencies
module sacl_row_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 92
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sacl_way_logic.sv
// tag compare, victim choice and lru/dirty update for one set row
// combinational; depends on sacl_pkg for the result type
module sacl_way_logic #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 20,
  parameter int unsigned AGE_W = 2,
  parameter int unsigned WAY_W = 2
) (
  input  logic                        is_write_i,
  input  logic [TAG_W-1:0]            tag_i,
  input  logic [WAYS-1:0]             valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]  tags_i,
  input  logic [WAYS-1:0]             dirty_i,
  input  logic [WAYS-1:0][AGE_W-1:0]  ages_i,
  output logic [WAYS-1:0][TAG_W-1:0]  tags_o,
  output logic [WAYS-1:0]             dirty_o,
  output logic [WAYS-1:0][AGE_W-1:0]  ages_o,
  output logic [WAY_W-1:0]            sel_o,
  output sacl_pkg::res_t              res_o
);

  localparam logic [AGE_W-1:0] AgeMax = AGE_W'(WAYS - 1);

  logic [WAYS-1:0][TAG_W-1:0] tag_m;
  logic [WAYS-1:0]            dirty_m;
  logic [WAYS-1:0][AGE_W-1:0] age_m;
  logic [WAYS-1:0]            hit_vec;
  logic                       hit;
  logic                       any_inv;
  logic [WAY_W-1:0]           hit_way;
  logic [WAY_W-1:0]           inv_way;
  logic [WAY_W-1:0]           lru_way;
  logic [AGE_W-1:0]           best_age;
  logic [WAY_W-1:0]           sel;
  logic [AGE_W-1:0]           old_age;
  logic                       wb;

  // invalid ways read as cleared
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tag_m[w]   = valid_i[w] ? tags_i[w]  : '0;
      dirty_m[w] = valid_i[w] ? dirty_i[w] : 1'b0;
      age_m[w]   = valid_i[w] ? ages_i[w]  : '0;
      hit_vec[w] = valid_i[w] && (tag_m[w] == tag_i);
    end
  end

  assign hit     = |hit_vec;
  assign any_inv = ~&valid_i;

  // lowest matching way and lowest invalid way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        inv_way = WAY_W'(w);
      end
    end
  end

  // oldest way, lowest index among equals
  always_comb begin
    best_age = '0;
    lru_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (age_m[w] > best_age) begin
        best_age = age_m[w];
        lru_way  = WAY_W'(w);
      end
    end
  end

  assign sel     = hit ? hit_way : (any_inv ? inv_way : lru_way);
  assign old_age = age_m[sel];
  assign wb      = !hit && !any_inv && dirty_m[sel];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags_o[w]  = tag_m[w];
      dirty_o[w] = dirty_m[w];
      ages_o[w]  = age_m[w];
      if (WAY_W'(w) == sel) begin
        ages_o[w] = '0;
        if (hit) begin
          dirty_o[w] = dirty_m[w] | is_write_i;
        end else begin
          tags_o[w]  = tag_i;
          dirty_o[w] = is_write_i;
        end
      end else if ((!hit || (age_m[w] < old_age)) && (age_m[w] < AgeMax)) begin
        ages_o[w] = age_m[w] + AGE_W'(1);
      end
    end
  end

  assign sel_o = sel;

  always_comb begin
    res_o.hit        = hit;
    res_o.way        = sacl_pkg::WAY_OUT_W'(sel);
    res_o.writeback  = wb;
    res_o.victim_tag = wb ? sacl_pkg::VTAG_OUT_W'(tag_m[sel]) : '0;
  end

endmodule

// File: src/set_assoc_cache_lru_lookup.sv
// set-associative cache lookup, lru replacement, write-back / write-allocate
// the set row is read at the accepting edge, the ways are compared in the next
// cycle and the response is registered when the request stage advances
// throughput: one request per cycle while responses are taken; a held response
// keeps the request stage full, which holds off the request side
// reset clears the valid bits (flip-flops) and handshake state, not the row memory
module set_assoc_cache_lru_lookup #(
  parameter int unsigned WAYS        = sacl_pkg::DEF_WAYS,
  parameter int unsigned SET_BITS    = sacl_pkg::DEF_SET_BITS,
  parameter int unsigned OFFSET_BITS = sacl_pkg::DEF_OFFSET_BITS,
  parameter int unsigned ADDR_BITS   = sacl_pkg::DEF_ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sacl_req_if.sink          req_i,
  sacl_rsp_if.source        rsp_o
);

  localparam int          TagBits  = int'(ADDR_BITS) - int'(SET_BITS) - int'(OFFSET_BITS);
  localparam int unsigned TagW     = (TagBits > 0) ? TagBits : 1;
  localparam int unsigned SetW     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned NumSets  = 1 << SET_BITS;
  localparam int unsigned WayW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AgeW     = WayW;
  localparam int unsigned RowW     = WAYS * (TagW + 1 + AgeW);

  logic                      accept;
  logic                      adv;
  logic [SetW-1:0]           in_set;
  logic [TagW-1:0]           in_tag;

  logic                      stg_vld_q;
  logic                      stg_op_q;
  logic [TagW-1:0]           stg_tag_q;
  logic [SetW-1:0]           stg_set_q;

  logic                      fwd_sel_q;
  logic [RowW-1:0]           fwd_row_q;
  logic [RowW-1:0]           ram_rdata;
  logic [RowW-1:0]           row_cur;
  logic [RowW-1:0]           row_new;

  logic [WAYS-1:0]           vld_q [NumSets];
  logic [WAYS-1:0]           vld_cur;

  logic [WAYS-1:0][TagW-1:0] tags_r;
  logic [WAYS-1:0]           dirty_r;
  logic [WAYS-1:0][AgeW-1:0] ages_r;
  logic [WAYS-1:0][TagW-1:0] tags_w;
  logic [WAYS-1:0]           dirty_w;
  logic [WAYS-1:0][AgeW-1:0] ages_w;
  logic [WayW-1:0]           sel_way;

  sacl_pkg::res_t            res;
  sacl_pkg::res_t            out_q;
  logic                      out_vld_q;

  assign in_tag = TagW'(req_i.address >> (SET_BITS + OFFSET_BITS));
  assign in_set = (SET_BITS > 0) ? SetW'(req_i.address >> OFFSET_BITS) : '0;

  assign adv         = stg_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !stg_vld_q || adv;
  assign accept      = req_i.valid && req_i.ready;

  // request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      fwd_sel_q <= 1'b0;
    end else begin
      if (accept) begin
        stg_vld_q <= 1'b1;
        // retiring request writes the same set this cycle: take its row
        fwd_sel_q <= adv && (in_set == stg_set_q);
      end else if (adv) begin
        stg_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_op_q  <= req_i.operation;
      stg_tag_q <= in_tag;
      stg_set_q <= in_set;
      fwd_row_q <= row_new;
    end
  end

  sacl_row_ram #(
    .DEPTH  (NumSets),
    .ADDR_W (SetW),
    .DATA_W (RowW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (stg_set_q),
    .wdata_i (row_new),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  assign row_cur = fwd_sel_q ? fwd_row_q : ram_rdata;
  assign {tags_r, dirty_r, ages_r} = row_cur;
  assign vld_cur = vld_q[stg_set_q];

  sacl_way_logic #(
    .WAYS  (WAYS),
    .TAG_W (TagW),
    .AGE_W (AgeW),
    .WAY_W (WayW)
  ) u_way_logic (
    .is_write_i (stg_op_q == sacl_pkg::OP_WRITE),
    .tag_i      (stg_tag_q),
    .valid_i    (vld_cur),
    .tags_i     (tags_r),
    .dirty_i    (dirty_r),
    .ages_i     (ages_r),
    .tags_o     (tags_w),
    .dirty_o    (dirty_w),
    .ages_o     (ages_w),
    .sel_o      (sel_way),
    .res_o      (res)
  );

  assign row_new = {tags_w, dirty_w, ages_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSets; s++) begin
        vld_q[s] <= '0;
      end
    end else if (adv) begin
      vld_q[stg_set_q][sel_way] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.hit        = out_q.hit;
  assign rsp_o.way        = out_q.way;
  assign rsp_o.writeback  = out_q.writeback;
  assign rsp_o.victim_tag = out_q.victim_tag;

endmodule

// File: bench/set_assoc_cache_lru_lookup_tb.sv
`timescale 1ns / 100ps
// testbench for the set-associative lru cache lookup: directed corner requests and random read/write traffic
// depends on sacl_pkg, sacl_req_if / sacl_rsp_if and set_assoc_cache_lru_lookup
module set_assoc_cache_lru_lookup_tb;

  localparam int unsigned WAYS     = sacl_pkg::DEF_WAYS;
  localparam int unsigned SET_W    = sacl_pkg::DEF_SET_BITS;
  localparam int unsigned OFF_W    = sacl_pkg::DEF_OFFSET_BITS;
  localparam int unsigned ADDR_W   = sacl_pkg::DEF_ADDR_BITS;
  localparam int unsigned TAG_W    = ADDR_W - SET_W - OFF_W;
  localparam int unsigned NUM_SETS = 1 << SET_W;

  class lookup_scoreboard;
    logic [TAG_W-1:0] line_tag   [NUM_SETS][WAYS];
    bit               line_valid [NUM_SETS][WAYS];
    bit               line_dirty [NUM_SETS][WAYS];
    int unsigned      line_age   [NUM_SETS][WAYS];
    sacl_pkg::res_t   expected_q [$];
    int unsigned      mismatches;

    function new();
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_tag[s][w]   = '0;
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          line_age[s][w]   = 0;
        end
      end
      mismatches = 0;
    endfunction

    function void age_up(int unsigned s, int unsigned w);
      if (line_age[s][w] < WAYS - 1) line_age[s][w]++;
    endfunction

    // apply one accepted request to the cache image and queue its response
    function void note_request(logic op, logic [ADDR_W-1:0] addr);
      int unsigned      s, sel, old_age, best;
      logic [TAG_W-1:0] t;
      bit               hit, found;
      sacl_pkg::res_t   r;
      s   = addr[SET_W+OFF_W-1:OFF_W];
      t   = addr[ADDR_W-1:SET_W+OFF_W];
      hit = 1'b0;
      sel = 0;
      r   = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (!hit && line_valid[s][w] && line_tag[s][w] == t) begin
          hit = 1'b1;
          sel = w;
        end
      end
      if (hit) begin
        old_age = line_age[s][sel];
        for (int w = 0; w < WAYS; w++)
          if (w != sel && line_age[s][w] < old_age) age_up(s, w);
        line_age[s][sel] = 0;
        if (op == sacl_pkg::OP_WRITE) line_dirty[s][sel] = 1'b1;
      end else begin
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
          if (!found && !line_valid[s][w]) begin
            found = 1'b1;
            sel   = w;
          end
        end
        if (!found) begin
          // oldest way, lowest index among equals
          best = 0;
          sel  = 0;
          for (int w = 0; w < WAYS; w++) begin
            if (line_age[s][w] > best) begin
              best = line_age[s][w];
              sel  = w;
            end
          end
          if (line_dirty[s][sel]) begin
            r.writeback  = 1'b1;
            r.victim_tag = sacl_pkg::VTAG_OUT_W'(line_tag[s][sel]);
          end
        end
        line_tag[s][sel]   = t;
        line_valid[s][sel] = 1'b1;
        line_dirty[s][sel] = (op == sacl_pkg::OP_WRITE);
        line_age[s][sel]   = 0;
        for (int w = 0; w < WAYS; w++)
          if (w != sel) age_up(s, w);
      end
      r.hit = hit;
      r.way = sel[sacl_pkg::WAY_OUT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_response(sacl_pkg::res_t got);
      sacl_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: response with no request pending, expected none, actual %0h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit) report("hit", want.hit, got.hit);
      if (got.way !== want.way) report("way", want.way, got.way);
      if (got.writeback !== want.writeback)
        report("writeback", want.writeback, got.writeback);
      if (got.victim_tag !== want.victim_tag)
        report("victim_tag", want.victim_tag, got.victim_tag);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sacl_req_if #(.ADDR_BITS(ADDR_W)) req_ch ();
  sacl_rsp_if rsp_ch ();

  set_assoc_cache_lru_lookup dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  lookup_scoreboard sb = new();
  bit               send_idle = 1'b1;
  bit               recv_idle = 1'b1;
  int unsigned      hold_len  = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rst_n           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = sacl_pkg::OP_READ;
    req_ch.address   = '0;
    rsp_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        @(negedge clk) rsp_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 9);
        @(negedge clk) rsp_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        @(negedge clk) rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_monitor
    sacl_pkg::res_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.hit        = rsp_ch.hit;
      got.way        = rsp_ch.way;
      got.writeback  = rsp_ch.writeback;
      got.victim_tag = rsp_ch.victim_tag;
      sb.check_response(got);
    end
  end

  task automatic send_request(logic op, logic [ADDR_W-1:0] addr);
    int unsigned n;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk) req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.address   <= addr;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, addr);
  endtask

  function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] t, int unsigned s,
                                                  int unsigned off);
    logic [ADDR_W-1:0] a;
    a = '0;
    a[ADDR_W-1:SET_W+OFF_W]      = t;
    a[SET_W+OFF_W-1:OFF_W]       = s[SET_W-1:0];
    a[OFF_W-1:0]                 = off[OFF_W-1:0];
    return a;
  endfunction

  // mostly a few hot sets with a small tag pool so hits and evictions are common
  task automatic send_mixed(int unsigned count);
    int unsigned      hot_sets [4];
    logic [TAG_W-1:0] hot_tags [6];
    logic             op;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        foreach (hot_sets[k]) hot_sets[k] = $urandom_range(0, NUM_SETS - 1);
        foreach (hot_tags[k]) hot_tags[k] = TAG_W'($urandom);
      end
      op = $urandom_range(0, 1) ? sacl_pkg::OP_WRITE : sacl_pkg::OP_READ;
      if ($urandom_range(0, 99) < 85)
        send_request(op, line_addr(hot_tags[$urandom_range(0, 5)],
                                   hot_sets[$urandom_range(0, 3)],
                                   $urandom_range(0, (1 << OFF_W) - 1)));
      else
        send_request(op, $urandom);
    end
  endtask

  // drop the request first so the last one is not taken again
  task automatic wait_drained();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    @(posedge rst_n);
    // address extremes, read hit on a dirty line
    send_request(sacl_pkg::OP_READ, '0);
    send_request(sacl_pkg::OP_READ, '0);
    send_request(sacl_pkg::OP_WRITE, '1);
    send_request(sacl_pkg::OP_READ, line_addr('1, NUM_SETS - 1, 0));
    // fill a set with dirty lines, then evict with writeback
    for (int t = 1; t <= 4; t++)
      send_request(sacl_pkg::OP_WRITE, line_addr(TAG_W'(t), 5, t));
    send_request(sacl_pkg::OP_WRITE, line_addr(TAG_W'(5), 5, 0));
    send_request(sacl_pkg::OP_READ, line_addr(TAG_W'(3), 5, 7));
    send_request(sacl_pkg::OP_READ, line_addr(TAG_W'(6), 5, (1 << OFF_W) - 1));
    // clean fills, a write hit in the middle of the age order, clean and dirty victims
    for (int t = 'h10; t <= 'h13; t++)
      send_request(sacl_pkg::OP_READ, line_addr(TAG_W'(t), 9, 0));
    send_request(sacl_pkg::OP_WRITE, line_addr(TAG_W'('h12), 9, 3));
    for (int t = 'h20; t <= 'h23; t++)
      send_request(sacl_pkg::OP_READ, line_addr(TAG_W'(t), 9, 0));
    // push the all-ones tag out of the last set
    for (int t = 0; t <= 3; t++)
      send_request(sacl_pkg::OP_WRITE, line_addr(TAG_W'(t), NUM_SETS - 1, 0));

    send_mixed(500);

    // long response hold-off so the block backs up into the request side
    hold_len = 80;
    send_mixed(40);
    wait_drained();

    send_mixed(900);
    wait_drained();

    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_mixed(400);
    @(negedge clk) req_ch.valid <= 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("set_assoc_cache_lru_lookup_tb OK");
    end else begin
      $display("set_assoc_cache_lru_lookup_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("set_assoc_cache_lru_lookup_tb NOT OK");
    $finish;
  end

endmodule
